@@ design/baseline_hysteresis_touch_detector_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the detector top level and bhtd_merge
// Each macro expects aclk and aresetn in scope.
// ---------------------------------------------------------------------------
`ifndef BASELINE_HYSTERESIS_TOUCH_DETECTOR_ASSERT_SVH
`define BASELINE_HYSTERESIS_TOUCH_DETECTOR_ASSERT_SVH

// condition holds at every edge out of reset
`define BHTD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define BHTD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define BHTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/bhtd_pkg.sv @@
// ---------------------------------------------------------------------------
// bhtd_pkg
// Types and fixed constants of the baseline hysteresis touch detector.
// ---------------------------------------------------------------------------
package bhtd_pkg;

    // fixed field widths
    localparam int MAX_CH         = 8;
    localparam int SAMPLE_FIELD_W = 10;
    localparam int THR_W          = 10;
    localparam int TOL_W          = 13;
    localparam int CODE_W         = 8;
    localparam int MAP_W          = 24;
    localparam int POS_W          = 3;
    localparam int CMP_W          = 12;   // sample plus two 10-bit margins
    localparam int CFG_IDX_W      = 3;

    // register reset values
    localparam logic [THR_W-1:0]  ON_THRESHOLD_RST     = 10'd6;
    localparam logic [THR_W-1:0]  HYSTERESIS_RST       = 10'd2;
    localparam logic [TOL_W-1:0]  STABLE_TOLERANCE_RST = 13'd5;
    localparam logic [CODE_W-1:0] CODE_OFFSET_RST      = 8'd20;
    localparam logic [MAP_W-1:0]  POSITION_MAP_RST     = 24'h2EF0A6;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ON_THRESHOLD     = 3'd0,
        REG_HYSTERESIS       = 3'd1,
        REG_STABLE_TOLERANCE = 3'd2,
        REG_CODE_OFFSET      = 3'd3,
        REG_POSITION_MAP     = 3'd4
    } cfg_reg_t;

    // result kinds
    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_CALIB = 1'b1;

    typedef struct packed {
        logic [THR_W-1:0]  on_threshold;
        logic [THR_W-1:0]  hysteresis;
        logic [TOL_W-1:0]  stable_tolerance;
        logic [CODE_W-1:0] code_offset;
        logic [MAP_W-1:0]  position_map;
    } cfg_t;

    // what one lane found for the current snapshot
    typedef struct packed {
        logic              stable;
        logic              change;
        logic [CODE_W-1:0] code;
    } lane_res_t;

    // results of one snapshot, waiting to be sent word by word
    typedef struct packed {
        logic                          calib;
        logic [MAX_CH-1:0]             mask;
        logic [MAX_CH-1:0][CODE_W-1:0] code;
    } batch_t;

endpackage

@@ design/baseline_hysteresis_touch_detector.sv @@
// ---------------------------------------------------------------------------
// baseline_hysteresis_touch_detector
// Touch detector: calibrates per-channel baselines from a sliding window,
// then reports on/off changes per channel with hysteresis.
// ---------------------------------------------------------------------------
// Usage:
//   s_* takes one snapshot of eight samples per word (valid/ready); only the
//   first CHANNELS samples and their low SAMPLE_BITS bits are used.
//   m_* sends result words: kind, event_byte and last (set on the final word
//   of a snapshot). A snapshot that yields nothing sends no word.
//   cfg_* writes one register per accepted word and is always ready.
// Timing:
//   A snapshot is evaluated by all lanes in the cycle it is accepted. Its
//   words pass through the batch registers and then the output register to
//   m_*, one per cycle while m_ready is high. A snapshot yields at most
//   CHANNELS words; the next snapshot is accepted in the cycle the previous
//   one's last word enters the output register.
// Reset:
//   aresetn clears the window, active flags and calibration state and loads
//   register defaults; s_ready is high as soon as reset is released.
// Stall:
//   While m_ready is low the output word holds; one further snapshot can be
//   taken and parked, then s_ready drops.
// ---------------------------------------------------------------------------
`include "baseline_hysteresis_touch_detector_assert.svh"

module baseline_hysteresis_touch_detector #(
    parameter int CHANNELS    = 8,
    parameter int WINDOW_ROWS = 6,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bhtd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bhtd_pkg::MAP_W-1:0]           cfg_data,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [bhtd_pkg::SAMPLE_FIELD_W-1:0]  s_sample_0,
    input  logic [bhtd_pkg::SAMPLE_FIELD_W-1:0]  s_sample_1,
    input  logic [bhtd_pkg::SAMPLE_FIELD_W-1:0]  s_sample_2,
    input  logic [bhtd_pkg::SAMPLE_FIELD_W-1:0]  s_sample_3,
    input  logic [bhtd_pkg::SAMPLE_FIELD_W-1:0]  s_sample_4,
    input  logic [bhtd_pkg::SAMPLE_FIELD_W-1:0]  s_sample_5,
    input  logic [bhtd_pkg::SAMPLE_FIELD_W-1:0]  s_sample_6,
    input  logic [bhtd_pkg::SAMPLE_FIELD_W-1:0]  s_sample_7,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_kind,
    output logic [bhtd_pkg::CODE_W-1:0]          m_event_byte,
    output logic                                 m_last
);
    import bhtd_pkg::*;

    localparam int SW = (SAMPLE_BITS < SAMPLE_FIELD_W) ? SAMPLE_BITS : SAMPLE_FIELD_W;
    localparam int RW = $clog2(WINDOW_ROWS);

    cfg_t                                cfg_reg;
    cfg_t                                cfg_next;
    logic                                calibrated_reg;
    logic                                calibrated_next;
    logic [RW-1:0]                       window_row_reg;
    logic [RW-1:0]                       window_row_next;

    logic [MAX_CH-1:0][SAMPLE_FIELD_W-1:0] samples;
    lane_res_t                           lane_res [CHANNELS];
    logic [CHANNELS-1:0]                 stable_vec;
    logic                                all_stable;
    logic                                take;
    logic                                commit;
    logic                                load_ok;
    batch_t                              batch;

    assign samples = {s_sample_7, s_sample_6, s_sample_5, s_sample_4,
                      s_sample_3, s_sample_2, s_sample_1, s_sample_0};

    assign cfg_ready = 1'b1;
    assign s_ready   = load_ok;
    assign take      = s_valid && s_ready;

    // register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_ON_THRESHOLD:     cfg_next.on_threshold     = cfg_data[THR_W-1:0];
                REG_HYSTERESIS:       cfg_next.hysteresis       = cfg_data[THR_W-1:0];
                REG_STABLE_TOLERANCE: cfg_next.stable_tolerance = cfg_data[TOL_W-1:0];
                REG_CODE_OFFSET:      cfg_next.code_offset      = cfg_data[CODE_W-1:0];
                REG_POSITION_MAP:     cfg_next.position_map     = cfg_data[MAP_W-1:0];
                default: ;
            endcase
        end
    end

    // lanes
    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        bhtd_lane #(
            .LANE        (c),
            .WINDOW_ROWS (WINDOW_ROWS),
            .SW          (SW),
            .RW          (RW)
        ) u_lane (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .cfg_i         (cfg_reg),
            .sample_i      (samples[c][SW-1:0]),
            .row_i         (window_row_reg),
            .take_i        (take),
            .calibrating_i (!calibrated_reg),
            .commit_i      (commit),
            .res_o         (lane_res[c])
        );
        assign stable_vec[c] = lane_res[c].stable;
    end

    assign all_stable = &stable_vec;
    assign commit     = take && !calibrated_reg && all_stable;

    // combine lane findings into one batch
    always_comb begin
        batch       = '0;
        batch.calib = !calibrated_reg && all_stable;
        for (int c = 0; c < CHANNELS; c++) begin
            batch.mask[c] = calibrated_reg && lane_res[c].change;
            batch.code[c] = lane_res[c].code;
        end
    end

    // mark calibration done on commit, else advance the window row, wrap at the last row
    always_comb begin
        calibrated_next = calibrated_reg;
        window_row_next = window_row_reg;
        if (commit) begin
            calibrated_next = 1'b1;
        end else if (take && !calibrated_reg) begin
            window_row_next = (window_row_reg == RW'(WINDOW_ROWS - 1)) ? '0
                              : window_row_reg + RW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.on_threshold     <= ON_THRESHOLD_RST;
            cfg_reg.hysteresis       <= HYSTERESIS_RST;
            cfg_reg.stable_tolerance <= STABLE_TOLERANCE_RST;
            cfg_reg.code_offset      <= CODE_OFFSET_RST;
            cfg_reg.position_map     <= POSITION_MAP_RST;
            calibrated_reg           <= 1'b0;
            window_row_reg           <= '0;
        end else begin
            cfg_reg        <= cfg_next;
            calibrated_reg <= calibrated_next;
            window_row_reg <= window_row_next;
        end
    end

    bhtd_merge u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load_i       (take),
        .batch_i      (batch),
        .load_ok_o    (load_ok),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_event_byte (m_event_byte),
        .m_last       (m_last)
    );

    `BHTD_ASSERT_NEXT(a_calib_sticky, calibrated_reg, calibrated_reg, "calibration state dropped")
    `BHTD_ASSERT_ALWAYS(a_row_range, window_row_reg <= RW'(WINDOW_ROWS - 1), "window row out of range")
    `BHTD_ASSERT_NEXT(a_row_frozen, calibrated_reg, $stable(window_row_reg), "window row moved after calibration")

endmodule

@@ design/bhtd_lane.sv @@
// ---------------------------------------------------------------------------
// bhtd_lane
// One channel: calibration window column with running sum, baseline and
// hysteresis on/off detector.
// ---------------------------------------------------------------------------
module bhtd_lane #(
    parameter int LANE        = 0,
    parameter int WINDOW_ROWS = 6,
    parameter int SW          = 10,
    parameter int RW          = 3
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  bhtd_pkg::cfg_t         cfg_i,
    input  logic [SW-1:0]          sample_i,
    input  logic [RW-1:0]          row_i,
    input  logic                   take_i,
    input  logic                   calibrating_i,
    input  logic                   commit_i,
    output bhtd_pkg::lane_res_t    res_o
);
    import bhtd_pkg::*;

    localparam int SUMW = SW + $clog2(WINDOW_ROWS);
    localparam int CW   = (SUMW > TOL_W) ? SUMW : TOL_W;

    logic [SW-1:0]    col_reg [WINDOW_ROWS];
    logic [SUMW-1:0]  sum_reg;
    logic [SUMW-1:0]  sum_next;
    logic [SW-1:0]    base_reg;
    logic             active_reg;
    logic             active_next;

    logic [SUMW-1:0]  scaled;
    logic [SUMW-1:0]  gap;
    logic [CMP_W-1:0] margin;
    logic [CMP_W-1:0] s_ext;
    logic [CMP_W-1:0] b_ext;
    logic             now_on;
    logic [POS_W-1:0] pos;

    // replace the oldest row in the running column sum
    assign sum_next = sum_reg - SUMW'(col_reg[row_i]) + SUMW'(sample_i);
    assign scaled   = SUMW'(SUMW'(sample_i) * SUMW'(WINDOW_ROWS));
    assign gap      = (scaled >= sum_next) ? (scaled - sum_next) : (sum_next - scaled);

    // wider margin to turn on than to stay on
    assign margin = active_reg ? CMP_W'(cfg_i.on_threshold)
                               : CMP_W'(cfg_i.on_threshold) + CMP_W'(cfg_i.hysteresis);
    assign s_ext  = CMP_W'(sample_i);
    assign b_ext  = CMP_W'(base_reg);
    assign now_on = (s_ext > b_ext + margin) || (s_ext + margin < b_ext);

    assign active_next = take_i && !calibrating_i ? now_on : active_reg;

    // report stability and change, build the event code
    assign pos          = cfg_i.position_map[POS_W*LANE +: POS_W];
    assign res_o.stable = (CW'(gap) <= CW'(cfg_i.stable_tolerance));
    assign res_o.change = (now_on != active_reg);
    assign res_o.code   = CODE_W'({pos, now_on}) + cfg_i.code_offset;

    // window column and running sum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < WINDOW_ROWS; r++) begin
                col_reg[r] <= '0;
            end
            sum_reg <= '0;
        end else if (take_i && calibrating_i) begin
            col_reg[row_i] <= sample_i;
            sum_reg        <= sum_next;
        end
    end

    // latch baseline when calibration completes
    always_ff @(posedge aclk) begin
        if (commit_i) begin
            base_reg <= sample_i;
        end
    end

    // track on/off state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
        end
    end

endmodule

@@ design/bhtd_merge.sv @@
// ---------------------------------------------------------------------------
// bhtd_merge
// Collects the lane findings of one snapshot and sends them out one word per
// cycle unless stalled, lowest channel first, through a registered output stage.
// ---------------------------------------------------------------------------
`include "baseline_hysteresis_touch_detector_assert.svh"

module bhtd_merge (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             load_i,
    input  bhtd_pkg::batch_t                 batch_i,
    output logic                             load_ok_o,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_kind,
    output logic [bhtd_pkg::CODE_W-1:0]      m_event_byte,
    output logic                             m_last
);
    import bhtd_pkg::*;

    logic                          calib_reg;
    logic                          calib_next;
    logic [MAX_CH-1:0]             mask_reg;
    logic [MAX_CH-1:0]             mask_next;
    logic [MAX_CH-1:0][CODE_W-1:0] code_reg;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          out_kind_reg;
    logic [CODE_W-1:0]             out_byte_reg;
    logic                          out_last_reg;

    logic                          pending;
    logic [MAX_CH-1:0]             pick;
    logic [MAX_CH-1:0]             rest;
    logic                          entry_last;
    logic [CODE_W-1:0]             entry_code;
    logic                          move;

    // pick the lowest pending channel
    assign pending    = calib_reg || (mask_reg != '0);
    assign pick       = mask_reg & (~mask_reg + MAX_CH'(1));
    assign rest       = mask_reg & ~pick;
    assign entry_last = calib_reg || (rest == '0);
    assign move       = pending && (!out_valid_reg || m_ready);
    assign load_ok_o  = !pending || (move && entry_last);

    always_comb begin
        entry_code = '0;
        for (int c = 0; c < MAX_CH; c++) begin
            entry_code = entry_code | (code_reg[c] & {CODE_W{pick[c]}});
        end
    end

    // advance the batch
    always_comb begin
        calib_next = calib_reg;
        mask_next  = mask_reg;
        if (load_i) begin
            calib_next = batch_i.calib;
            mask_next  = batch_i.mask;
        end else if (move) begin
            if (calib_reg) begin
                calib_next = 1'b0;
            end else begin
                mask_next = rest;
            end
        end
    end

    // hold output word until taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (move) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            calib_reg     <= 1'b0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            calib_reg     <= calib_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_i) begin
            code_reg <= batch_i.code;
        end
        if (move) begin
            out_kind_reg <= calib_reg ? KIND_CALIB : KIND_EVENT;
            out_byte_reg <= calib_reg ? '0 : entry_code;
            out_last_reg <= entry_last;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_kind       = out_kind_reg;
    assign m_event_byte = out_byte_reg;
    assign m_last       = out_last_reg;

    `BHTD_ASSERT_IMPLY(a_calib_word, m_valid && m_kind == KIND_CALIB, m_last && m_event_byte == '0, "calibration word must be last and zero")
    `BHTD_ASSERT_IMPLY(a_load_ok, load_i, load_ok_o, "batch loaded while previous one still pending")
    `BHTD_ASSERT_ALWAYS(a_calib_alone, !calib_reg || mask_reg == '0, "calibration word mixed with channel events")

endmodule
